>>> rtl/spf_pkg.sv
// shared types and constants of the smallest-prime-factor factoriser
package spf_pkg;

   // default table depth, one entry per value
   localparam int TABLE_SIZE_DEF = 65536;

   // field widths
   localparam int VALUE_W  = 16;
   localparam int FACTOR_W = 16;
   localparam int STATUS_W = 2;

   // results per input, and the counter that tracks them
   localparam int MAX_RESULTS = 15;
   localparam int COUNT_W     = $clog2(MAX_RESULTS);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   // one table entry: smallest prime factor (zero while unmarked, i.e. prime)
   // and the cofactor left once that factor is divided out
   typedef struct packed {
      logic [FACTOR_W-1:0] least_factor;
      logic [FACTOR_W-1:0] cofactor;
   } entry_type;

endpackage

>>> rtl/smallest_prime_factor_factorizer_top.sv
// Smallest-prime-factor factoriser: the table lives in one TABLE_SIZE-deep
// ram whose entries each hold a value's smallest prime factor and the
// cofactor left after dividing it out. After reset busy stays high while the
// table is built: a fill pass writes every entry (even values from two up
// get 2), then a sieve reads each odd candidate p with p*p below TABLE_SIZE
// and, for a prime, sweeps p*p, p*p+p, ... at one entry a cycle, marking the
// unmarked ones. Once built, a beat on start while busy is low takes one
// value. Values 0, 1 and values outside the table give their single result
// in the cycle after the beat with busy staying low. Any other value gives
// one result per prime factor, in ascending order, on consecutive cycles;
// the beat's table read and the result register lie between the beat and the
// first result. Each factor costs one table read on the ram's read port,
// which then returns the next entry at the cofactor. busy drops as the last
// result appears. Results come as a one-cycle strobe on rsp_valid; the
// receiver cannot stall them.
module smallest_prime_factor_factorizer_top #(
   parameter int TABLE_SIZE = spf_pkg::TABLE_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [spf_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   output logic [spf_pkg::FACTOR_W-1:0] rsp_factor,
   output logic                         rsp_last,
   output logic [spf_pkg::STATUS_W-1:0] rsp_status
);

   localparam int VALUE_W  = spf_pkg::VALUE_W;
   localparam int FACTOR_W = spf_pkg::FACTOR_W;
   localparam int STATUS_W = spf_pkg::STATUS_W;
   localparam int COUNT_W  = spf_pkg::COUNT_W;
   localparam int ADDR_W   = $clog2(TABLE_SIZE);
   localparam int CNT_W    = ADDR_W + 1;

   localparam logic [CNT_W-1:0]    SIZE_C      = CNT_W'(TABLE_SIZE);
   localparam logic [ADDR_W-1:0]   LAST_ADDR   = ADDR_W'(TABLE_SIZE - 1);
   localparam bit                  NARROW_TBL  = TABLE_SIZE < (2 ** VALUE_W);
   localparam logic [VALUE_W-1:0]  VALUE_LIMIT = VALUE_W'(TABLE_SIZE);
   localparam logic [COUNT_W-1:0]  COUNT_LAST  = COUNT_W'(spf_pkg::MAX_RESULTS - 1);
   localparam logic [FACTOR_W-1:0] FACTOR_TWO  = FACTOR_W'(2);
   localparam logic [FACTOR_W-1:0] FACTOR_ONE  = FACTOR_W'(1);

   typedef enum logic [5:0] {
      ST_FILL      = 6'b000001,
      ST_PRIME_RD  = 6'b000010,
      ST_PRIME_CHK = 6'b000100,
      ST_MARK      = 6'b001000,
      ST_IDLE      = 6'b010000,
      ST_FACT      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]    prime_ff, prime_in;
   logic [CNT_W-1:0]    square_ff, square_in;
   logic [CNT_W-1:0]    mult_ff, mult_in;
   logic [FACTOR_W-1:0] cofac_ff, cofac_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [FACTOR_W-1:0] pend_cof_ff, pend_cof_in;
   logic [FACTOR_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FACTOR_W-1:0] rsp_factor_ff, rsp_factor_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   spf_pkg::entry_type  wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   spf_pkg::entry_type  rd_data;

   logic [CNT_W-1:0]    prime_next;
   logic [CNT_W-1:0]    square_next;
   logic                sieve_done;
   logic                mult_live;
   logic                entry_prime;
   logic [FACTOR_W-1:0] fact_factor;
   logic [FACTOR_W-1:0] fact_cof;
   logic                fact_last;
   spf_pkg::entry_type  fill_entry;
   logic                value_bad;

   // factor table
   spf_ram #(
      .WIDTH ($bits(spf_pkg::entry_type)),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sieve stepping: next odd candidate and its square, (p+2)^2 = p^2 + 4p + 4
   assign prime_next  = prime_ff + CNT_W'(2);
   assign square_next = square_ff + {prime_ff[CNT_W-3:0], 2'b00} + CNT_W'(4);
   assign sieve_done  = square_next >= SIZE_C;
   assign mult_live   = mult_ff < SIZE_C;

   // initial entry: 2 for even values from two up, unmarked otherwise
   always_comb begin
      fill_entry.least_factor = (!fill_ff[0] && (fill_ff != '0)) ? FACTOR_TWO : '0;
      fill_entry.cofactor     = FACTOR_W'(fill_ff >> 1);
   end

   // factor step from the entry read at the remainder
   assign entry_prime = rd_data.least_factor == '0;
   assign fact_factor = entry_prime ? rem_ff : rd_data.least_factor;
   assign fact_cof    = entry_prime ? FACTOR_ONE : rd_data.cofactor;
   assign fact_last   = (fact_cof <= FACTOR_ONE) || (count_ff == COUNT_LAST);

   // input values with no factor walk
   assign value_bad = (req_value == '0) || (NARROW_TBL && (req_value >= VALUE_LIMIT));

   // write port: fill pass, else sieve write-back of an unmarked multiple
   always_comb begin
      wr_en   = (state_ff == ST_FILL) || (pend_ff && (rd_data.least_factor == '0));
      wr_addr = (state_ff == ST_FILL) ? fill_ff : pend_addr_ff;
      if (state_ff == ST_FILL) begin
         wr_data = fill_entry;
      end else begin
         wr_data.least_factor = FACTOR_W'(prime_ff);
         wr_data.cofactor     = pend_cof_ff;
      end
   end

   // read port address
   always_comb begin
      case (state_ff)
         ST_IDLE:     rd_addr = ADDR_W'(req_value);
         ST_MARK:     rd_addr = ADDR_W'(mult_ff);
         ST_FACT:     rd_addr = ADDR_W'(fact_cof);
         default:     rd_addr = ADDR_W'(prime_ff);
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      prime_in      = prime_ff;
      square_in     = square_ff;
      mult_in       = mult_ff;
      cofac_in      = cofac_ff;
      pend_in       = 1'b0;
      pend_addr_in  = ADDR_W'(mult_ff);
      pend_cof_in   = cofac_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_factor_in = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = spf_pkg::STATUS_OK;
      case (state_ff)
         ST_FILL: begin
            fill_in = fill_ff + ADDR_W'(1);
            if (fill_ff == LAST_ADDR) begin
               state_in = ST_PRIME_RD;
            end
         end
         ST_PRIME_RD: begin
            state_in = ST_PRIME_CHK;
         end
         ST_PRIME_CHK: begin
            if (rd_data.least_factor == '0) begin
               // prime: sweep its multiples from its square
               mult_in  = square_ff;
               cofac_in = FACTOR_W'(prime_ff);
               state_in = ST_MARK;
            end else begin
               prime_in  = prime_next;
               square_in = square_next;
               state_in  = sieve_done ? ST_IDLE : ST_PRIME_RD;
            end
         end
         ST_MARK: begin
            if (mult_live) begin
               pend_in  = 1'b1;
               mult_in  = mult_ff + prime_ff;
               cofac_in = cofac_ff + FACTOR_ONE;
            end else begin
               // last write-back lands this cycle
               prime_in  = prime_next;
               square_in = square_next;
               state_in  = sieve_done ? ST_IDLE : ST_PRIME_RD;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (value_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = spf_pkg::STATUS_INVALID;
               end else if (req_value == VALUE_W'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = spf_pkg::STATUS_NONE;
               end else begin
                  rem_in   = FACTOR_W'(req_value);
                  count_in = '0;
                  state_in = ST_FACT;
               end
            end
         end
         ST_FACT: begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = fact_factor;
            rsp_last_in   = fact_last;
            if (fact_last) begin
               state_in = ST_IDLE;
            end else begin
               rem_in   = fact_cof;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         prime_ff     <= CNT_W'(3);
         square_ff    <= CNT_W'(9);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         prime_ff     <= prime_in;
         square_ff    <= square_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mult_ff       <= mult_in;
      cofac_ff      <= cofac_in;
      pend_addr_ff  <= pend_addr_in;
      pend_cof_ff   <= pend_cof_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ports
   assign busy       = state_ff != ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   // no result beat while the table is being built
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL || state_ff == ST_PRIME_RD || state_ff == ST_PRIME_CHK
       || state_ff == ST_MARK) |-> !rsp_valid_ff)
      else $error("result beat during table build");

   // sieve write-back never collides with the address being read
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_FILL) |-> (wr_addr != rd_addr))
      else $error("write-back collides with read address");

   // an ok factor is at least two
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == spf_pkg::STATUS_OK) |-> (rsp_factor_ff >= FACTOR_TWO))
      else $error("ok result with factor below two");

   // a beat that is not ok closes its item and carries no factor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != spf_pkg::STATUS_OK)
      |-> (rsp_last_ff && rsp_factor_ff == '0))
      else $error("non-ok result not final or with factor");

   // every factor walk ends with a last beat before going idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FACT && state_in == ST_IDLE) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("factor walk ended without a last beat");

endmodule

>>> rtl/spf_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module spf_ram #(
   parameter int WIDTH = $bits(spf_pkg::entry_type),
   parameter int DEPTH = spf_pkg::TABLE_SIZE_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> verif/tb.sv
// self-checking testbench for the smallest-prime-factor factoriser
module tb;

   localparam int TABLE_SIZE     = spf_pkg::TABLE_SIZE_DEF;
   localparam int VALUE_W        = spf_pkg::VALUE_W;
   localparam int FACTOR_W       = spf_pkg::FACTOR_W;
   localparam int STATUS_W       = spf_pkg::STATUS_W;
   localparam int MAX_RESULTS    = spf_pkg::MAX_RESULTS;
   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 9;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int DRAIN_CYCLES   = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_ITEMS   = 70;

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic                last;
      logic [STATUS_W-1:0] status;
   } factor_beat_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic [FACTOR_W-1:0] rsp_factor;
   logic                rsp_last;
   logic [STATUS_W-1:0] rsp_status;

   // own copy of the smallest-prime-factor table
   logic [FACTOR_W-1:0] least_prime [TABLE_SIZE];
   factor_beat_type     expected_factors [$];

   int fail_count;
   int values_taken;
   int beats_checked;
   int zeros_taken;
   int ones_taken;

   smallest_prime_factor_factorizer_top #(
      .TABLE_SIZE (TABLE_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_factor (rsp_factor),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // sieve: evens from two up get 2, each odd prime marks its unmarked multiples from its square
   function automatic void build_least_prime();
      for (int n = 0; n < TABLE_SIZE; n++) begin
         least_prime[n] = (n % 2 == 0 && n >= 2) ? FACTOR_W'(2) : FACTOR_W'(n);
      end
      for (int p = 3; p * p < TABLE_SIZE; p += 2) begin
         if (int'(least_prime[p]) == p) begin
            for (int m = p * p; m < TABLE_SIZE; m += p) begin
               if (int'(least_prime[m]) == m) least_prime[m] = FACTOR_W'(p);
            end
         end
      end
   endfunction

   function automatic void push_beat(input int factor, input bit last,
                                     input logic [STATUS_W-1:0] status);
      factor_beat_type beat;
      beat.factor = FACTOR_W'(factor);
      beat.last   = last;
      beat.status = status;
      expected_factors.insert(expected_factors.size(), beat);
   endfunction

   // expected factor beats for one accepted value
   function automatic void factorise_value(input logic [VALUE_W-1:0] value);
      int rem;
      int f;
      int count;
      rem   = int'(value);
      count = 0;
      if (rem == 1) begin
         push_beat(0, 1'b1, spf_pkg::STATUS_NONE);
      end else if (rem == 0 || rem >= TABLE_SIZE) begin
         push_beat(0, 1'b1, spf_pkg::STATUS_INVALID);
      end else begin
         while (rem > 1 && count < MAX_RESULTS) begin
            f = int'(least_prime[rem]);
            if (f < 2) f = rem;
            rem = rem / f;
            push_beat(f, (rem <= 1 || count == MAX_RESULTS - 1), spf_pkg::STATUS_OK);
            count++;
         end
      end
   endfunction

   // compare each result beat with the oldest expectation, then predict new values
   always @(posedge clock) begin : check_factors
      factor_beat_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_factors.size() == 0) begin
               $error("unexpected beat: factor %0d last %0d status %0d",
                      rsp_factor, rsp_last, rsp_status);
               fail_count++;
            end else begin
               want = expected_factors.pop_front();
               beats_checked++;
               if (rsp_factor !== want.factor) begin
                  $error("factor: expected %0d, got %0d", want.factor, rsp_factor);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            factorise_value(req_value);
            values_taken++;
            if (req_value == '0) zeros_taken++;
            if (req_value == VALUE_W'(1)) ones_taken++;
         end
      end
   end

   // one beat on the request side; start is left high for a following value
   task automatic send_value(input int value);
      start     <= 1'b1;
      req_value <= VALUE_W'(value);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start     <= 1'b0;
         req_value <= VALUE_W'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(4, 1);
      return $urandom_range(40, 10);
   endfunction

   // product of random small primes, kept within 16 bits
   function automatic int smooth_value();
      int primes [6] = '{2, 3, 5, 7, 11, 13};
      int n;
      int p;
      n = 1;
      repeat ($urandom_range(16, 1)) begin
         p = primes[$urandom_range(5)];
         if (n * p <= 65535) n = n * p;
      end
      return n;
   endfunction

   // extremes, primes, long factor chains and the special values
   task automatic test_edge_values();
      int values [] = '{0, 1, 2, 3, 4, 65535, 65534, 65521, 32768, 49152,
                        59049, 65025, 255, 256, 257, 43690, 21845, 1, 0, 30030};
      foreach (values[i]) begin
         send_value(values[i]);
         idle_for(pick_gap());
      end
   endtask

   // values with no gaps, special ones mixed between long chains
   task automatic test_back_to_back();
      int values [] = '{32768, 0, 1, 6, 1, 0, 65535, 9973, 2};
      foreach (values[i]) send_value(values[i]);
      idle_for(1);
   endtask

   // gap first, so the caller can drop start right after the last beat
   task automatic test_random_values();
      int roll;
      int value;
      repeat (RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 8) value = 0;
         else if (roll < 16) value = 1;
         else if (roll < 40) value = smooth_value();
         else if (roll < 50) value = (1 << $urandom_range(15)) * $urandom_range(3, 1);
         else value = $urandom_range(65535);
         idle_for(pick_gap());
         send_value(value & 16'hffff);
      end
   endtask

   initial begin
      fail_count    = 0;
      values_taken  = 0;
      beats_checked = 0;
      zeros_taken   = 0;
      ones_taken    = 0;
      build_least_prime();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_edge_values();
      test_back_to_back();
      test_random_values();
      start <= 1'b0;

      // drain outstanding factor beats
      for (int i = 0; i < DRAIN_CYCLES && expected_factors.size() != 0; i++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_factors.size() != 0) begin
         $error("%0d expected factor beats never arrived", expected_factors.size());
         fail_count++;
      end

      $display("run covered %0d values (%0d zero, %0d one) and %0d factor beats",
               values_taken, zeros_taken, ones_taken, beats_checked);
      $display("with edge values, back-to-back requests and random gaps");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/spf_pkg.sv
rtl/spf_ram.sv
rtl/smallest_prime_factor_factorizer_top.sv
verif/tb.sv
